// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL file that carries concurrent checks.
// Every macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising edge outside reset.
`define HPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds at a rising edge outside reset.
`define HPA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/hpa_pkg.sv =====
// Shared types and codes of the handle pool allocator.
// No dependencies; used by the controller, the datapath and the top level.
package hpa_pkg;

  typedef enum logic [2:0] {
    MODE_ACQUIRE = 3'd0,
    MODE_RELEASE = 3'd1,
    MODE_UPDATE  = 3'd2,
    MODE_INIT    = 3'd3,
    MODE_APPLY   = 3'd4,
    MODE_CLEAR   = 3'd5
  } mode_e;

  localparam logic [1:0] STS_OK         = 2'd0;
  localparam logic [1:0] STS_EXHAUSTED  = 2'd1;
  localparam logic [1:0] STS_NOT_ACTIVE = 2'd2;

  localparam logic CFG_MIN_POOL = 1'b0;
  localparam logic CFG_MAX_POOL = 1'b1;

  localparam int CFG_WIDTH  = 7;
  localparam int CNT_OUT_W  = 7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cap;
    logic pop;
    logic create;
    logic scan_rst;
    logic scan_adv;
    logic insert;
    logic slot_fail;
    logic set_exh;
    logic release_hit;
    logic not_found;
    logic shrink;
    logic load_cnt;
    logic fill_step;
    logic clear;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] mode;
    logic       free_nz;
    logic       can_create;
    logic       hnd_ok;
    logic       upd_shrink;
    logic       upd_grow;
    logic       apl_grow;
    logic       apl_shrink;
    logic       slot_free;
    logic       idx_last;
    logic       hit;
    logic       miss;
    logic       fill_done;
    logic       out_free;
  } sts_t;

endpackage

// ===== rtl/hpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/hpa_datapath.sv =====
// Datapath of the handle pool allocator: limit registers, free FIFO and active
// table memories, counters, scan index and result register. Uses hpa_pkg, hpa_ram.
module hpa_datapath #(
  parameter int POOL_DEPTH   = 64,
  parameter int HANDLE_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [hpa_pkg::CFG_WIDTH-1:0]    cfg_wdata_i,
  input  logic [2:0]                       mode_i,
  input  logic [HANDLE_WIDTH-1:0]          handle_in_i,
  input  logic                             out_ready_i,
  input  hpa_pkg::cmd_t                    cmd_i,
  output hpa_pkg::sts_t                    sts_o,
  output logic                             out_valid_o,
  output logic [HANDLE_WIDTH-1:0]          handle_out_o,
  output logic [1:0]                       status_o,
  output logic [hpa_pkg::CNT_OUT_W-1:0]    free_count_o,
  output logic [hpa_pkg::CNT_OUT_W-1:0]    busy_count_o
);

  localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CW = $clog2(POOL_DEPTH + 1);
  localparam int TW = CW + 1;
  localparam int LW = (CW > hpa_pkg::CFG_WIDTH) ? CW : hpa_pkg::CFG_WIDTH;
  localparam int SW = AW + 1;

  logic [hpa_pkg::CFG_WIDTH-1:0] min_q, max_q;
  logic [AW-1:0]           head_q;
  logic [CW-1:0]           free_q, active_q;
  logic [HANDLE_WIDTH-1:0] next_q;
  logic [POOL_DEPTH-1:0]   valid_q;
  logic [TW-1:0]           cnt_q;
  logic [AW-1:0]           idx_q, cmp_idx_q;
  logic                    cmp_vld_q;
  logic                    popped_q;
  logic [2:0]              mode_q;
  logic [HANDLE_WIDTH-1:0] hin_q, cand_q;
  logic [HANDLE_WIDTH-1:0] hout_q;
  logic [1:0]              res_sts_q;
  logic                    out_valid_q;
  logic [HANDLE_WIDTH-1:0] out_hnd_q;
  logic [1:0]              out_sts_q;
  logic [CW-1:0]           out_free_q, out_busy_q;

  // Limits: order the pair, then cap at the depth.
  logic [hpa_pkg::CFG_WIDTH-1:0] lo7, hi7;
  logic [LW-1:0]                 lo_ext, hi_ext;
  logic [CW-1:0]                 lim_lo, lim_hi;
  logic [TW-1:0]                 total, tgt_raw, tgt, cnt_d;
  logic [SW-1:0]                 tail_sum;
  logic [AW-1:0]                 tail;
  logic                          fifo_has_room;
  logic                          fifo_we;
  logic [HANDLE_WIDTH-1:0]       fifo_wdata, fifo_rdata, tab_rdata;
  logic                          tab_we;

  always_comb begin
    lo7    = (min_q < max_q) ? min_q : max_q;
    hi7    = (min_q < max_q) ? max_q : min_q;
    lo_ext = LW'(lo7);
    hi_ext = LW'(hi7);
    if (lo_ext > LW'(POOL_DEPTH)) lo_ext = LW'(POOL_DEPTH);
    if (hi_ext > LW'(POOL_DEPTH)) hi_ext = LW'(POOL_DEPTH);
    lim_lo = CW'(lo_ext);
    lim_hi = CW'(hi_ext);
  end

  assign total    = TW'(free_q) + TW'(active_q);
  assign tail_sum = SW'(head_q) + SW'(free_q);
  assign tail     = (tail_sum >= SW'(POOL_DEPTH)) ? AW'(tail_sum - SW'(POOL_DEPTH))
                                                  : AW'(tail_sum);
  assign fifo_has_room = free_q < CW'(POOL_DEPTH);

  assign tgt_raw = total + TW'(lim_lo >> 1);
  assign tgt     = (tgt_raw > TW'(lim_hi)) ? TW'(lim_hi) : tgt_raw;

  always_comb begin
    case (mode_q)
      hpa_pkg::MODE_UPDATE: cnt_d = tgt - total;
      hpa_pkg::MODE_INIT:   cnt_d = TW'(lim_lo);
      hpa_pkg::MODE_APPLY:  cnt_d = TW'(lim_lo) - total;
      default:              cnt_d = '0;
    endcase
  end

  always_comb begin
    sts_o.mode       = mode_q;
    sts_o.free_nz    = free_q != '0;
    sts_o.hnd_ok     = (next_q != '1) && (next_q != '0);
    sts_o.can_create = (total < TW'(lim_hi)) && (active_q < CW'(POOL_DEPTH));
    sts_o.upd_shrink = (TW'(free_q) > (TW'(lim_lo) << 1)) &&
                       (total > TW'(lim_lo));
    sts_o.upd_grow   = (free_q < (lim_lo >> 1)) && (total < TW'(lim_hi));
    sts_o.apl_grow   = total < TW'(lim_lo);
    sts_o.apl_shrink = total > TW'(lim_hi);
    sts_o.slot_free  = !valid_q[idx_q];
    sts_o.idx_last   = idx_q == AW'(POOL_DEPTH - 1);
    sts_o.hit        = cmp_vld_q && valid_q[cmp_idx_q] && (tab_rdata == hin_q);
    sts_o.miss       = cmp_vld_q && (cmp_idx_q == AW'(POOL_DEPTH - 1)) && !sts_o.hit;
    sts_o.fill_done  = (cnt_q == '0) || (total >= TW'(lim_hi)) || !sts_o.hnd_ok;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  // Free FIFO writes: push back a popped handle, a released one, or a new one.
  always_comb begin
    fifo_we    = 1'b0;
    fifo_wdata = cand_q;
    if (cmd_i.slot_fail && popped_q) begin
      fifo_we = 1'b1;
    end else if (cmd_i.release_hit) begin
      fifo_we    = fifo_has_room;
      fifo_wdata = hin_q;
    end else if (cmd_i.fill_step) begin
      fifo_we    = fifo_has_room;
      fifo_wdata = next_q;
    end
  end

  assign tab_we = cmd_i.insert;

  hpa_ram #(.WIDTH(HANDLE_WIDTH), .DEPTH(POOL_DEPTH)) u_fifo_ram (
    .clk_i   (clk_i),
    .we_i    (fifo_we),
    .waddr_i (tail),
    .wdata_i (fifo_wdata),
    .raddr_i (head_q),
    .rdata_o (fifo_rdata)
  );

  hpa_ram #(.WIDTH(HANDLE_WIDTH), .DEPTH(POOL_DEPTH)) u_table_ram (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (idx_q),
    .wdata_i (cand_q),
    .raddr_i (idx_q),
    .rdata_o (tab_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q       <= hpa_pkg::CFG_WIDTH'(8);
      max_q       <= hpa_pkg::CFG_WIDTH'(32);
      head_q      <= '0;
      free_q      <= '0;
      active_q    <= '0;
      next_q      <= HANDLE_WIDTH'(1);
      valid_q     <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      cmp_idx_q   <= '0;
      cmp_vld_q   <= 1'b0;
      popped_q    <= 1'b0;
      mode_q      <= '0;
      hout_q      <= '0;
      res_sts_q   <= hpa_pkg::STS_OK;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == hpa_pkg::CFG_MIN_POOL) min_q <= cfg_wdata_i;
        if (cfg_idx_i == hpa_pkg::CFG_MAX_POOL) max_q <= cfg_wdata_i;
      end
      if (cmd_i.cap) begin
        mode_q    <= mode_i;
        hout_q    <= '0;
        res_sts_q <= hpa_pkg::STS_OK;
        popped_q  <= 1'b0;
      end
      if (cmd_i.pop) begin
        head_q   <= (head_q == AW'(POOL_DEPTH - 1)) ? '0 : head_q + 1'b1;
        free_q   <= free_q - 1'b1;
        popped_q <= 1'b1;
      end
      if (cmd_i.create) begin
        next_q <= next_q + 1'b1;
      end
      if (cmd_i.scan_rst) begin
        idx_q     <= '0;
        cmp_vld_q <= 1'b0;
      end
      if (cmd_i.scan_adv) begin
        if (idx_q != AW'(POOL_DEPTH - 1)) idx_q <= idx_q + 1'b1;
        cmp_idx_q <= idx_q;
        cmp_vld_q <= 1'b1;
      end
      if (cmd_i.insert) begin
        valid_q[idx_q] <= 1'b1;
        active_q       <= active_q + 1'b1;
        hout_q         <= cand_q;
      end
      if (cmd_i.slot_fail) begin
        res_sts_q <= hpa_pkg::STS_EXHAUSTED;
        if (popped_q) free_q <= free_q + 1'b1;
      end
      if (cmd_i.set_exh) begin
        res_sts_q <= hpa_pkg::STS_EXHAUSTED;
      end
      if (cmd_i.release_hit) begin
        valid_q[cmp_idx_q] <= 1'b0;
        active_q           <= active_q - 1'b1;
        if (fifo_has_room) free_q <= free_q + 1'b1;
      end
      if (cmd_i.not_found) begin
        res_sts_q <= hpa_pkg::STS_NOT_ACTIVE;
      end
      if (cmd_i.shrink && (free_q > lim_lo)) begin
        free_q <= lim_lo;
      end
      if (cmd_i.load_cnt) begin
        cnt_q <= cnt_d;
      end
      if (cmd_i.fill_step) begin
        next_q <= next_q + 1'b1;
        cnt_q  <= cnt_q - 1'b1;
        if (fifo_has_room) free_q <= free_q + 1'b1;
      end
      if (cmd_i.clear) begin
        head_q   <= '0;
        free_q   <= '0;
        active_q <= '0;
        valid_q  <= '0;
        next_q   <= HANDLE_WIDTH'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) hin_q <= handle_in_i;
    if (cmd_i.pop) cand_q <= fifo_rdata;
    if (cmd_i.create) cand_q <= next_q;
    if (cmd_i.out_load) begin
      out_hnd_q  <= hout_q;
      out_sts_q  <= res_sts_q;
      out_free_q <= free_q;
      out_busy_q <= active_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign handle_out_o = out_hnd_q;
  assign status_o     = out_sts_q;
  assign free_count_o = hpa_pkg::CNT_OUT_W'(out_free_q);
  assign busy_count_o = hpa_pkg::CNT_OUT_W'(out_busy_q);

endmodule

// ===== rtl/hpa_ctrl.sv =====
// Controller state machine of the handle pool allocator.
// Uses hpa_pkg; drives commands into hpa_datapath and reads its status.
module hpa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  hpa_pkg::sts_t sts_i,
  output hpa_pkg::cmd_t cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_DISPATCH = 7'b0000010,
    ST_POP      = 7'b0000100,
    ST_SLOT     = 7'b0001000,
    ST_SEARCH   = 7'b0010000,
    ST_FILL     = 7'b0100000,
    ST_DONE     = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = state_q == ST_IDLE;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_d = ST_DONE;
        case (sts_i.mode)
          hpa_pkg::MODE_ACQUIRE: begin
            if (sts_i.free_nz) begin
              state_d = ST_POP;
            end else if (sts_i.can_create && sts_i.hnd_ok) begin
              cmd_o.create   = 1'b1;
              cmd_o.scan_rst = 1'b1;
              state_d        = ST_SLOT;
            end else begin
              cmd_o.set_exh = 1'b1;
            end
          end
          hpa_pkg::MODE_RELEASE: begin
            cmd_o.scan_rst = 1'b1;
            state_d        = ST_SEARCH;
          end
          hpa_pkg::MODE_UPDATE: begin
            if (sts_i.upd_shrink) begin
              cmd_o.shrink = 1'b1;
            end else if (sts_i.upd_grow) begin
              cmd_o.load_cnt = 1'b1;
              state_d        = ST_FILL;
            end
          end
          hpa_pkg::MODE_INIT: begin
            cmd_o.load_cnt = 1'b1;
            state_d        = ST_FILL;
          end
          hpa_pkg::MODE_APPLY: begin
            if (sts_i.apl_grow) begin
              cmd_o.load_cnt = 1'b1;
              state_d        = ST_FILL;
            end else if (sts_i.apl_shrink) begin
              cmd_o.shrink = 1'b1;
            end
          end
          hpa_pkg::MODE_CLEAR: begin
            cmd_o.clear = 1'b1;
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_POP: begin
        cmd_o.pop      = 1'b1;
        cmd_o.scan_rst = 1'b1;
        state_d        = ST_SLOT;
      end
      ST_SLOT: begin
        if (sts_i.slot_free) begin
          cmd_o.insert = 1'b1;
          state_d      = ST_DONE;
        end else if (sts_i.idx_last) begin
          cmd_o.slot_fail = 1'b1;
          state_d         = ST_DONE;
        end else begin
          cmd_o.scan_adv = 1'b1;
        end
      end
      ST_SEARCH: begin
        if (sts_i.hit) begin
          cmd_o.release_hit = 1'b1;
          state_d           = ST_DONE;
        end else if (sts_i.miss) begin
          cmd_o.not_found = 1'b1;
          state_d         = ST_DONE;
        end else begin
          cmd_o.scan_adv = 1'b1;
        end
      end
      ST_FILL: begin
        if (sts_i.fill_done) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.fill_step = 1'b1;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/handle_pool_allocator.sv =====
// Handle pool allocator: hands out numbered handles (first one is 1) from a
// FIFO of free handles, creating new ones up to the max limit, and takes them
// back on release. One transaction in gives exactly one result transaction out.
// Transactions are worked one at a time. Clear, update/apply shrink, idle modes
// and an acquire that finds the pool exhausted go straight to the result
// register; an acquire pops a handle from the free FIFO or creates a new one,
// then scans the active table for the first empty slot (linear slot scan);
// release scans the table entry by entry until the match or the last entry,
// one table-memory read per cycle; initialize/update/apply growth creates
// one handle at a time. A new transaction is taken while the previous result
// still waits in the output register. Limits may be written in either order;
// both are capped at POOL_DEPTH. Write the limits only while the block is idle.
`include "assert_macros.svh"

module handle_pool_allocator #(
  parameter int POOL_DEPTH   = 64,
  parameter int HANDLE_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration: index 0 min_pool, index 1 max_pool.
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [hpa_pkg::CFG_WIDTH-1:0] cfg_wdata_i,
  // Request channel.
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0]                    mode_i,
  input  logic [HANDLE_WIDTH-1:0]       handle_in_i,
  // Result channel.
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [HANDLE_WIDTH-1:0]       handle_out_o,
  output logic [1:0]                    status_o,
  output logic [hpa_pkg::CNT_OUT_W-1:0] free_count_o,
  output logic [hpa_pkg::CNT_OUT_W-1:0] busy_count_o
);

  hpa_pkg::cmd_t cmd;
  hpa_pkg::sts_t sts;

  // Sequence each transaction: dispatch on mode, scan, fill, then hold the
  // result until the output register frees up.
  hpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold limits, the free FIFO, the active table and the result register.
  hpa_datapath #(
    .POOL_DEPTH   (POOL_DEPTH),
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .mode_i       (mode_i),
    .handle_in_i  (handle_in_i),
    .out_ready_i  (out_ready_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .handle_out_o (handle_out_o),
    .status_o     (status_o),
    .free_count_o (free_count_o),
    .busy_count_o (busy_count_o)
  );

  // A result must never overwrite one that is still waiting.
  `HPA_ASSERT(a_out_load_free, cmd.out_load |-> (!out_valid_o || out_ready_i), "result overwritten")
  // Only one transaction in flight.
  `HPA_ASSERT(a_one_in_flight, (in_valid_i && in_ready_o) |=> !in_ready_o, "second transaction taken")
  // A pop is only issued when the free FIFO holds a handle.
  `HPA_ASSERT_NEVER(a_pop_empty, cmd.pop && !sts.free_nz, "pop from empty free FIFO")

endmodule

// ===== bench/handle_pool_allocator_tb.sv =====
// Self-checking bench for handle_pool_allocator: drives requests and limits,
// predicts every result with a scoreboard class. Depends on hpa_pkg and the RTL.
`timescale 1ns / 1ps

module handle_pool_allocator_tb;

  localparam int DEPTH = 64;
  localparam logic [15:0] HND_TOP = 16'hFFFF;

  typedef struct packed {
    logic [15:0] hnd;
    logic [1:0]  sts;
    logic [6:0]  free_cnt;
    logic [6:0]  busy_cnt;
  } pool_result_t;

  // Shadow of the pool: predicts each result and checks what comes out.
  class pool_scoreboard;
    logic [15:0]  fifo_q[DEPTH];
    int           head, free_tot, busy_tot;
    bit           act_vld[DEPTH];
    logic [15:0]  act_hnd[DEPTH];
    logic [15:0]  next_hnd;
    logic [6:0]   min_reg, max_reg;
    int           lo, hi;
    pool_result_t pending[$];
    int           errors;

    function void clear_state();
      head = 0; free_tot = 0; busy_tot = 0; next_hnd = 16'd1;
      foreach (act_vld[i]) act_vld[i] = 0;
    endfunction

    function void set_reg(logic idx, logic [6:0] val);
      if (idx == hpa_pkg::CFG_MIN_POOL) min_reg = val;
      else max_reg = val;
    endfunction

    function logic [15:0] new_handle();
      logic [15:0] h;
      h = next_hnd;
      if (h == HND_TOP || h == 16'd0) return 16'd0;
      next_hnd = h + 16'd1;
      return h;
    endfunction

    function void push_free(logic [15:0] h);
      if (free_tot >= DEPTH) return;
      fifo_q[(head + free_tot) % DEPTH] = h;
      free_tot++;
    endfunction

    function bit insert_active(logic [15:0] h);
      for (int i = 0; i < DEPTH; i++) begin
        if (!act_vld[i]) begin
          act_vld[i] = 1; act_hnd[i] = h; busy_tot++;
          return 1;
        end
      end
      return 0;
    endfunction

    function void grow(int cnt);
      logic [15:0] h;
      for (int i = 0; i < cnt; i++) begin
        if (free_tot + busy_tot >= hi) break;
        h = new_handle();
        if (h == 16'd0) break;
        push_free(h);
      end
    endfunction

    function void trim();
      if (free_tot > lo) free_tot = lo;
    endfunction

    // Random active handle, or zero when the table is empty.
    function logic [15:0] pick_active();
      int idx[$];
      for (int i = 0; i < DEPTH; i++) if (act_vld[i]) idx = {idx, i};
      if (idx.size() == 0) return 16'd0;
      return act_hnd[idx[$urandom_range(idx.size() - 1)]];
    endfunction

    // Apply one accepted transaction and queue its result.
    function void note(logic [2:0] mode, logic [15:0] hin);
      pool_result_t r;
      logic [15:0] h;
      int tot, tgt;
      bit found;
      lo = (min_reg < max_reg) ? min_reg : max_reg;
      hi = (min_reg < max_reg) ? max_reg : min_reg;
      if (lo > DEPTH) lo = DEPTH;
      if (hi > DEPTH) hi = DEPTH;
      r.hnd = 16'd0;
      r.sts = hpa_pkg::STS_OK;
      tot = free_tot + busy_tot;
      case (mode)
        hpa_pkg::MODE_ACQUIRE: begin
          if (free_tot > 0) begin
            h = fifo_q[head];
            head = (head + 1) % DEPTH;
            free_tot--;
            if (insert_active(h)) r.hnd = h;
            else begin
              push_free(h); r.sts = hpa_pkg::STS_EXHAUSTED;
            end
          end else if (tot < hi && busy_tot < DEPTH) begin
            h = new_handle();
            if (h != 16'd0 && insert_active(h)) r.hnd = h;
            else r.sts = hpa_pkg::STS_EXHAUSTED;
          end else begin
            r.sts = hpa_pkg::STS_EXHAUSTED;
          end
        end
        hpa_pkg::MODE_RELEASE: begin
          found = 0;
          for (int i = 0; i < DEPTH; i++) begin
            if (act_vld[i] && act_hnd[i] == hin) begin
              act_vld[i] = 0; busy_tot--; push_free(hin); found = 1;
              break;
            end
          end
          if (!found) r.sts = hpa_pkg::STS_NOT_ACTIVE;
        end
        hpa_pkg::MODE_UPDATE: begin
          if (free_tot > 2 * lo && tot > lo) trim();
          else if (free_tot < lo / 2 && tot < hi) begin
            tgt = tot + lo / 2;
            if (tgt > hi) tgt = hi;
            if (tgt > tot) grow(tgt - tot);
          end
        end
        hpa_pkg::MODE_INIT: grow(lo);
        hpa_pkg::MODE_APPLY: begin
          if (tot < lo) grow(lo - tot);
          else if (tot > hi) trim();
        end
        hpa_pkg::MODE_CLEAR: clear_state();
        default: ;
      endcase
      r.free_cnt = free_tot[6:0];
      r.busy_cnt = busy_tot[6:0];
      pending = {pending, r};
    endfunction

    function void check(pool_result_t act);
      pool_result_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, act);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (act.hnd !== exp.hnd)
        $display("%0t: handle_out exp %0d got %0d", $time, exp.hnd, act.hnd);
      if (act.sts !== exp.sts)
        $display("%0t: status exp %0d got %0d", $time, exp.sts, act.sts);
      if (act.free_cnt !== exp.free_cnt)
        $display("%0t: free_count exp %0d got %0d", $time, exp.free_cnt, act.free_cnt);
      if (act.busy_cnt !== exp.busy_cnt)
        $display("%0t: busy_count exp %0d got %0d", $time, exp.busy_cnt, act.busy_cnt);
      if (act !== exp) errors++;
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic                          cfg_idx_i = 1'b0;
  logic [hpa_pkg::CFG_WIDTH-1:0] cfg_wdata_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic [2:0]                    mode_i = '0;
  logic [15:0]                   handle_in_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [15:0]                   handle_out_o;
  logic [1:0]                    status_o;
  logic [hpa_pkg::CNT_OUT_W-1:0] free_count_o;
  logic [hpa_pkg::CNT_OUT_W-1:0] busy_count_o;

  pool_scoreboard pool_sb = new();
  bit steady = 0;   // suppress idling on both sides while set

  handle_pool_allocator u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .mode_i, .handle_in_i,
    .out_valid_o, .out_ready_i, .handle_out_o, .status_o,
    .free_count_o, .busy_count_o
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #8_000_000;
    $display("** handle_pool_allocator: FAILED **");
    $finish;
  end

  // Result side: stall at random on the falling edge, check on the rising edge.
  initial begin
    forever begin
      @(negedge clk_i);
      out_ready_i <= steady || ($urandom_range(99) >= 27);
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i)
        pool_sb.check('{handle_out_o, status_o, free_count_o, busy_count_o});
    end
  end

  // Drive one request transaction; hold it until accepted, then log it.
  task automatic send_req(logic [2:0] mode, logic [15:0] hnd);
    @(negedge clk_i);
    if (!steady) begin
      while ($urandom_range(99) < 27) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i  <= 1'b1;
    mode_i      <= mode;
    handle_in_i <= hnd;
    do @(posedge clk_i); while (!in_ready_o);
    pool_sb.note(mode, hnd);
  endtask

  // Drain all results, then write one limit register while the block idles.
  task automatic write_limit(logic idx, logic [6:0] val);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pool_sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    pool_sb.set_reg(idx, val);
  endtask

  task automatic set_limits(logic [6:0] lo_val, logic [6:0] hi_val);
    write_limit(hpa_pkg::CFG_MIN_POOL, lo_val);
    write_limit(hpa_pkg::CFG_MAX_POOL, hi_val);
  endtask

  // Mostly well-formed traffic: acquires, live releases, limit and clear modes.
  task automatic random_req();
    int roll;
    logic [15:0] h;
    roll = $urandom_range(99);
    h = pool_sb.pick_active();
    if (roll < 38) send_req(hpa_pkg::MODE_ACQUIRE, 16'($urandom));
    else if (roll < 65) begin
      if (h == 16'd0) send_req(hpa_pkg::MODE_ACQUIRE, 16'd0);
      else send_req(hpa_pkg::MODE_RELEASE, h);
    end else if (roll < 71) send_req(hpa_pkg::MODE_RELEASE, 16'($urandom));
    else if (roll < 83) send_req(hpa_pkg::MODE_UPDATE, 16'($urandom));
    else if (roll < 89) send_req(hpa_pkg::MODE_INIT, 16'($urandom));
    else if (roll < 95) send_req(hpa_pkg::MODE_APPLY, 16'($urandom));
    else if (roll < 97) send_req(hpa_pkg::MODE_CLEAR, 16'($urandom));
    else send_req(3'($urandom_range(6, 7)), 16'($urandom));
  endtask

  initial begin
    pool_sb.min_reg = 7'd8;
    pool_sb.max_reg = 7'd32;
    pool_sb.clear_state();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: every mode, bad releases, limit extremes, swapped and capped limits.
    send_req(hpa_pkg::MODE_ACQUIRE, 16'hFFFF);
    send_req(hpa_pkg::MODE_RELEASE, 16'd1);
    send_req(hpa_pkg::MODE_RELEASE, 16'd1);
    send_req(hpa_pkg::MODE_RELEASE, 16'd0);
    send_req(hpa_pkg::MODE_RELEASE, 16'hFFFF);
    send_req(hpa_pkg::MODE_UPDATE, 16'd0);
    send_req(hpa_pkg::MODE_INIT, 16'd0);
    send_req(hpa_pkg::MODE_APPLY, 16'd0);
    send_req(hpa_pkg::MODE_ACQUIRE, 16'd0);
    send_req(3'd6, 16'h5A5A);
    send_req(3'd7, 16'hA5A5);
    send_req(hpa_pkg::MODE_CLEAR, 16'd0);
    send_req(hpa_pkg::MODE_ACQUIRE, 16'd0);
    set_limits(7'd64, 7'd64);
    send_req(hpa_pkg::MODE_INIT, 16'd0);
    send_req(hpa_pkg::MODE_UPDATE, 16'd0);
    set_limits(7'd0, 7'd0);
    send_req(hpa_pkg::MODE_APPLY, 16'd0);
    send_req(hpa_pkg::MODE_ACQUIRE, 16'd0);
    send_req(hpa_pkg::MODE_UPDATE, 16'd0);
    set_limits(7'd40, 7'd10);
    send_req(hpa_pkg::MODE_APPLY, 16'd0);
    send_req(hpa_pkg::MODE_UPDATE, 16'd0);
    set_limits(7'd127, 7'd100);
    send_req(hpa_pkg::MODE_INIT, 16'd0);
    send_req(hpa_pkg::MODE_CLEAR, 16'd0);

    // Random phases under changing limits; one phase runs without idling.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_limits(7'd8, 7'd32);
        1: set_limits(7'd64, 7'd64);
        2: set_limits(7'd0, 7'd64);
        3: set_limits(7'd127, 7'd127);
        4: set_limits(7'd20, 7'd5);
        default: set_limits(7'($urandom), 7'($urandom));
      endcase
      steady = (ph == 2);
      for (int n = 0; n < 255; n++) begin
        if (n == 128) set_limits(7'($urandom_range(0, 64)), 7'($urandom_range(0, 64)));
        random_req();
      end
      steady = 0;
    end

    set_limits(7'd8, 7'd32);
    send_req(hpa_pkg::MODE_ACQUIRE, 16'd0);
    send_req(hpa_pkg::MODE_INIT, 16'd0);
    send_req(hpa_pkg::MODE_UPDATE, 16'd0);
    send_req(hpa_pkg::MODE_CLEAR, 16'd0);
    send_req(hpa_pkg::MODE_ACQUIRE, 16'd0);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pool_sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (pool_sb.errors == 0 && pool_sb.pending.size() == 0) begin
      $display("** handle_pool_allocator: PASSED **");
    end else begin
      $display("** handle_pool_allocator: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/hpa_pkg.sv
rtl/hpa_ram.sv
rtl/hpa_datapath.sv
rtl/hpa_ctrl.sv
rtl/handle_pool_allocator.sv
bench/handle_pool_allocator_tb.sv
